// ===== rtl/core/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad package
// Shared widths, register indexes, reset coefficients, controller states and
// the request and response types of the serial multiplier.
// ----------------------------------------------------------------------------
package biq_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int STATE_W   = 24;
    localparam int RND_W     = STATE_W + 3;
    localparam int ACC_W     = STATE_W + 4;
    localparam int CNT_W     = $clog2(COEF_W);
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0 = 3'd0,
        CFG_B1 = 3'd1,
        CFG_B2 = 3'd2,
        CFG_A1 = 3'd3,
        CFG_A2 = 3'd4
    } cfg_idx_t;

    localparam logic signed [COEF_W-1:0] RST_B0 = 18'sd0;
    localparam logic signed [COEF_W-1:0] RST_B1 = 18'sd1406;
    localparam logic signed [COEF_W-1:0] RST_B2 = 18'sd0;
    localparam logic signed [COEF_W-1:0] RST_A1 = -18'sd120084;
    localparam logic signed [COEF_W-1:0] RST_A2 = 18'sd56322;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB1,
        ST_FB2,
        ST_FF0,
        ST_FF1,
        ST_FF2,
        ST_DONE
    } biq_state_t;

    typedef struct packed {
        logic                       start;
        logic signed [COEF_W-1:0]   coef;
        logic signed [STATE_W-1:0]  operand;
    } biq_mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [RND_W-1:0]    rnd;
    } biq_mul_rsp_t;

endpackage

// ===== rtl/core/biq_if.sv =====
// ----------------------------------------------------------------------------
// Biquad channels
// Valid/ready channels for input samples, filtered results and register
// writes.
// ----------------------------------------------------------------------------
interface biq_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [biq_pkg::SAMPLE_W-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface biq_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [biq_pkg::SAMPLE_W-1:0]   sample_out;
    logic                                  clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

interface biq_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [biq_pkg::CFG_IDX_W-1:0]         index;
    logic [biq_pkg::COEF_W-1:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/biq_serial_mult.sv =====
// ----------------------------------------------------------------------------
// Biquad serial multiplier
// Multiplies a coefficient by a state value one coefficient bit per cycle and
// rounds the product to twelve fraction bits, ties toward plus infinity.
// ----------------------------------------------------------------------------
module biq_serial_mult (
    input  logic                  clk,
    input  logic                  rst_n,
    input  biq_pkg::biq_mul_req_t req,
    output biq_pkg::biq_mul_rsp_t rsp
);
    import biq_pkg::*;

    logic [COEF_W-1:0]         coef_sr_reg;
    logic signed [STATE_W-1:0] op_reg;
    logic signed [STATE_W:0]   hi_reg;
    logic [2:0]                lo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic signed [STATE_W+1:0] addend;
    logic signed [STATE_W+1:0] sum;
    logic                      last_bit;

    assign last_bit = (cnt_reg == CNT_W'(COEF_W - 1));

    always_comb
    begin
        addend = '0;
        if (coef_sr_reg[0])
        begin
            if (last_bit)
                addend = -{{2{op_reg[STATE_W-1]}}, op_reg};
            else
                addend = {{2{op_reg[STATE_W-1]}}, op_reg};
        end
        sum = {hi_reg[STATE_W], hi_reg} + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            coef_sr_reg <= req.coef;
            op_reg      <= req.operand;
            hi_reg      <= '0;
            lo_reg      <= '0;
        end
        else if (busy_reg)
        begin
            coef_sr_reg <= {1'b0, coef_sr_reg[COEF_W-1:1]};
            hi_reg      <= sum[STATE_W+1:1];
            lo_reg      <= {sum[0], lo_reg[2:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rnd  = $signed({hi_reg, lo_reg[2:1]})
                    + $signed({{(RND_W-1){1'b0}}, lo_reg[0]});

endmodule

// ===== rtl/core/biquad_iir_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR filter unit
// One second-order direct form II section with Q2.16 coefficients, Q12.12
// state and Q4.12 samples, saturating the state and the output.
// ----------------------------------------------------------------------------
// From acceptance to a ready result, the five coefficient products run one
// after another through a single bit-serial multiplier, the first one
// starting at the edge that accepts the item, and the result is then
// written to the output register once it is free. A new item is accepted
// in the cycle after the previous one has reached the output register,
// even if that result has not yet been taken; no new item is accepted
// while one is in progress. Coefficient writes are taken in any cycle and
// should be made while the filter is idle.
module biquad_iir_filter_unit (
    input  logic   clk,
    input  logic   rst_n,
    biq_sample_if.sink  sample_chan,
    biq_result_if.source result_chan,
    biq_cfg_if.sink     cfg_chan
);
    import biq_pkg::*;

    localparam logic signed [ACC_W-1:0] WN_MAX  = ACC_W'((1 << (STATE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] WN_MIN  = -ACC_W'(1 << (STATE_W - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(1 << (SAMPLE_W - 1));

    biq_state_t state_reg, state_next;

    logic signed [COEF_W-1:0]   b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic signed [STATE_W-1:0]  delay_one_reg, delay_two_reg, wn_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       hit_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_clip_reg;

    biq_mul_req_t mul_req;
    biq_mul_rsp_t mul_rsp;

    logic signed [ACC_W-1:0]    rnd_ext, acc_sum, acc_dif;
    logic signed [STATE_W-1:0]  wn_sat;
    logic                       wn_hit;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic                       y_hit;
    logic                       in_fire, out_free;

    biq_serial_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign out_free          = !out_valid_reg || result_chan.ready;
    assign sample_chan.ready = (state_reg == ST_IDLE);
    assign in_fire           = sample_chan.valid && sample_chan.ready;
    assign cfg_chan.ready    = 1'b1;

    assign result_chan.valid      = out_valid_reg;
    assign result_chan.sample_out = out_sample_reg;
    assign result_chan.clipped    = out_clip_reg;

    assign rnd_ext = {mul_rsp.rnd[RND_W-1], mul_rsp.rnd};
    assign acc_sum = acc_reg + rnd_ext;
    assign acc_dif = acc_reg - rnd_ext;

    always_comb
    begin
        wn_hit = 1'b1;
        if (acc_dif > WN_MAX)
            wn_sat = WN_MAX[STATE_W-1:0];
        else if (acc_dif < WN_MIN)
            wn_sat = WN_MIN[STATE_W-1:0];
        else
        begin
            wn_sat = acc_dif[STATE_W-1:0];
            wn_hit = 1'b0;
        end

        y_hit = 1'b1;
        if (acc_reg > OUT_MAX)
            y_sat = OUT_MAX[SAMPLE_W-1:0];
        else if (acc_reg < OUT_MIN)
            y_sat = OUT_MIN[SAMPLE_W-1:0];
        else
        begin
            y_sat = acc_reg[SAMPLE_W-1:0];
            y_hit = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_FB1;
            ST_FB1:  if (mul_rsp.done) state_next = ST_FB2;
            ST_FB2:  if (mul_rsp.done) state_next = ST_FF0;
            ST_FF0:  if (mul_rsp.done) state_next = ST_FF1;
            ST_FF1:  if (mul_rsp.done) state_next = ST_FF2;
            ST_FF2:  if (mul_rsp.done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_req.start   = in_fire;
                mul_req.coef    = a1_reg;
                mul_req.operand = delay_one_reg;
            end
            ST_FB1:
            begin
                mul_req.start   = mul_rsp.done;
                mul_req.coef    = a2_reg;
                mul_req.operand = delay_two_reg;
            end
            ST_FB2:
            begin
                mul_req.start   = mul_rsp.done;
                mul_req.coef    = b0_reg;
                mul_req.operand = wn_sat;
            end
            ST_FF0:
            begin
                mul_req.start   = mul_rsp.done;
                mul_req.coef    = b1_reg;
                mul_req.operand = delay_one_reg;
            end
            ST_FF1:
            begin
                mul_req.start   = mul_rsp.done;
                mul_req.coef    = b2_reg;
                mul_req.operand = delay_two_reg;
            end
            ST_FF2, ST_DONE:
            begin
                mul_req = '0;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            b0_reg        <= RST_B0;
            b1_reg        <= RST_B1;
            b2_reg        <= RST_B2;
            a1_reg        <= RST_A1;
            a2_reg        <= RST_A2;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_chan.valid && cfg_chan.ready)
            begin
                unique case (cfg_idx_t'(cfg_chan.index))
                    CFG_B0:  b0_reg <= cfg_chan.data;
                    CFG_B1:  b1_reg <= cfg_chan.data;
                    CFG_B2:  b2_reg <= cfg_chan.data;
                    CFG_A1:  a1_reg <= cfg_chan.data;
                    CFG_A2:  a2_reg <= cfg_chan.data;
                    default: ;
                endcase
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
                delay_two_reg <= delay_one_reg;
                delay_one_reg <= wn_reg;
            end
            else if (result_chan.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    acc_reg <= {{(ACC_W-SAMPLE_W){sample_chan.sample_in[SAMPLE_W-1]}},
                                sample_chan.sample_in};
                    hit_reg <= 1'b0;
                end
            end
            ST_FB1:
            begin
                if (mul_rsp.done)
                    acc_reg <= acc_dif;
            end
            ST_FB2:
            begin
                if (mul_rsp.done)
                begin
                    wn_reg  <= wn_sat;
                    hit_reg <= wn_hit;
                    acc_reg <= '0;
                end
            end
            ST_FF0, ST_FF1, ST_FF2:
            begin
                if (mul_rsp.done)
                    acc_reg <= acc_sum;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_sample_reg <= y_sat;
                    out_clip_reg   <= hit_reg || y_hit;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== verif/biq_response_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad response checker
// Watches the register, sample and result channels of the filter, keeps its
// own copy of the coefficients and the two delay taps, predicts each
// filtered sample and compares every returned item with the oldest pending
// prediction.
// ----------------------------------------------------------------------------
module biq_response_checker (
    input  logic        clk,
    input  logic        rst_n,
    biq_sample_if       sample_chan,
    biq_result_if       result_chan,
    biq_cfg_if          cfg_chan,
    output int unsigned mismatches,
    output int unsigned pending
);
    import biq_pkg::*;

    localparam longint STATE_HI  = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_LO  = -(longint'(1) <<< (STATE_W - 1));
    localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_W - 1));
    localparam longint HALF_LSB  = longint'(1) <<< 15;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } filt_out_t;

    logic signed [COEF_W-1:0]  gain_b0;
    logic signed [COEF_W-1:0]  gain_b1;
    logic signed [COEF_W-1:0]  gain_b2;
    logic signed [COEF_W-1:0]  fb_a1;
    logic signed [COEF_W-1:0]  fb_a2;
    logic signed [STATE_W-1:0] w_recent;
    logic signed [STATE_W-1:0] w_older;
    filt_out_t                 filtered_q[$];
    filt_out_t                 got;
    filt_out_t                 want;

    // Q2.16 times Q12.12, rounded to nearest (ties up) back to 12 fraction bits.
    function automatic longint scaled_product(input logic signed [COEF_W-1:0]  coef,
                                              input logic signed [STATE_W-1:0] tap);
        return (longint'(coef) * longint'(tap) + HALF_LSB) >>> 16;
    endfunction

    function automatic void filter_step(input logic signed [SAMPLE_W-1:0] x);
        longint    wn;
        longint    y;
        logic      hit;
        filt_out_t res;
        hit = 1'b0;
        wn = longint'(x) - scaled_product(fb_a1, w_recent) - scaled_product(fb_a2, w_older);
        if (wn > STATE_HI)
        begin
            wn  = STATE_HI;
            hit = 1'b1;
        end
        else if (wn < STATE_LO)
        begin
            wn  = STATE_LO;
            hit = 1'b1;
        end
        y = scaled_product(gain_b0, STATE_W'(wn)) + scaled_product(gain_b1, w_recent)
            + scaled_product(gain_b2, w_older);
        if (y > SAMPLE_HI)
        begin
            y   = SAMPLE_HI;
            hit = 1'b1;
        end
        else if (y < SAMPLE_LO)
        begin
            y   = SAMPLE_LO;
            hit = 1'b1;
        end
        res.sample  = SAMPLE_W'(y);
        res.clipped = hit;
        filtered_q.push_back(res);
        w_older  = w_recent;
        w_recent = STATE_W'(wn);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_b0    = RST_B0;
            gain_b1    = RST_B1;
            gain_b2    = RST_B2;
            fb_a1      = RST_A1;
            fb_a2      = RST_A2;
            w_recent   = '0;
            w_older    = '0;
            filtered_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_chan.valid && cfg_chan.ready)
            begin
                case (cfg_idx_t'(cfg_chan.index))
                    CFG_B0: gain_b0 = cfg_chan.data;
                    CFG_B1: gain_b1 = cfg_chan.data;
                    CFG_B2: gain_b2 = cfg_chan.data;
                    CFG_A1: fb_a1 = cfg_chan.data;
                    CFG_A2: fb_a2 = cfg_chan.data;
                    default: ;
                endcase
            end
            if (result_chan.valid && result_chan.ready)
            begin
                got.sample  = result_chan.sample_out;
                got.clipped = result_chan.clipped;
                if (filtered_q.size() == 0)
                begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: unexpected item: sample_out=%0d clipped=%0b",
                                 $time, got.sample, got.clipped);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (got.sample !== want.sample || got.clipped !== want.clipped)
                    begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t: sample_out exp %0d got %0d, clipped exp %0b got %0b",
                                     $time, want.sample, got.sample, want.clipped,
                                     got.clipped);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (sample_chan.valid && sample_chan.ready)
                filter_step(sample_chan.sample_in);
            pending = filtered_q.size();
        end
    end

endmodule

// ===== verif/tb_biquad_iir_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Biquad IIR filter unit testbench
// Drives samples with random gaps, coefficient writes and random result
// back-pressure: directed passes over extreme samples with reset and extreme
// coefficients, then random low-pass, random, stable, extreme, feed-forward
// and reset-feedback phases. A checker predicts and compares every item.
// ----------------------------------------------------------------------------
module tb_biquad_iir_filter_unit;
    import biq_pkg::*;

    localparam logic [CFG_IDX_W-1:0]     IDX_SPARE_LO   = 3'd5;
    localparam logic [CFG_IDX_W-1:0]     IDX_SPARE_HI   = '1;
    localparam logic signed [COEF_W-1:0] COEF_MAX       = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN       = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam int                       PHASES         = 12;
    localparam int                       ITEMS_PER_PHASE = 125;
    localparam int                       DRAIN_CYCLES   = 120;

    typedef enum int {
        FILT_LOWPASS,
        FILT_RANDOM,
        FILT_STABLE,
        FILT_EXTREME,
        FILT_FIR,
        FILT_RESET_FB
    } filt_kind_t;

    logic        clk;
    logic        rst_n;
    bit          send_idle;
    bit          recv_stall;
    int unsigned mismatches;
    int unsigned pending;

    logic signed [SAMPLE_W-1:0] probe [0:7];

    biq_sample_if sample_chan ();
    biq_result_if result_chan ();
    biq_cfg_if    cfg_chan ();

    biquad_iir_filter_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_chan (sample_chan),
        .result_chan (result_chan),
        .cfg_chan    (cfg_chan)
    );

    biq_response_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_chan (sample_chan),
        .result_chan (result_chan),
        .cfg_chan    (cfg_chan),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("biquad_iir_filter_unit: mismatch");
        $finish;
    end

    initial
    begin
        int unsigned stall;
        result_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = recv_stall ? $urandom_range(0, 10) : 0;
            if (stall != 0)
            begin
                @(negedge clk);
                result_chan.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            result_chan.ready <= 1'b1;
            do @(posedge clk); while (!(result_chan.valid && result_chan.ready));
        end
    end

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [31:0] r;
        r = $urandom;
        return r[COEF_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return {{(SAMPLE_W-9){r[8]}}, r[8:0]};
            default: return r[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap != 0)
        begin
            sample_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_chan.valid     <= 1'b1;
        sample_chan.sample_in <= value;
        do @(posedge clk); while (!sample_chan.ready);
        @(negedge clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        cfg_chan.valid <= 1'b1;
        cfg_chan.index <= idx;
        cfg_chan.data  <= value;
        do @(posedge clk); while (!cfg_chan.ready);
        @(negedge clk);
    endtask

    task automatic load_filter(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                               input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                               input logic [COEF_W-1:0] a2);
        sample_chan.valid <= 1'b0;
        wait_idle();
        write_coef(CFG_B0, b0);
        write_coef(CFG_B1, b1);
        write_coef(CFG_B2, b2);
        write_coef(CFG_A1, a1);
        write_coef(CFG_A2, a2);
        write_coef(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), rand_coef());
        cfg_chan.valid <= 1'b0;
    endtask

    task automatic pick_filter(input filt_kind_t kind);
        int a1;
        int a2;
        int span;
        case (kind)
            FILT_LOWPASS:
                load_filter(RST_B0, RST_B1, RST_B2, RST_A1, RST_A2);
            FILT_STABLE:
            begin
                a2   = $urandom_range(0, 60000);
                span = 65536 + a2 - 2000;
                a1   = int'($urandom_range(0, 2 * span)) - span;
                load_filter(rand_coef(), rand_coef(), rand_coef(), COEF_W'(a1), COEF_W'(a2));
            end
            FILT_EXTREME:
                load_filter($urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                            $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                            $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                            $urandom_range(0, 1) ? COEF_MAX : COEF_MIN,
                            $urandom_range(0, 1) ? COEF_MAX : COEF_MIN);
            FILT_FIR:
                load_filter(rand_coef(), rand_coef(), rand_coef(), '0, '0);
            FILT_RESET_FB:
                load_filter(rand_coef(), rand_coef(), rand_coef(), RST_A1, RST_A2);
            default:
                load_filter(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
        endcase
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        send_idle             = 1'b0;
        recv_stall            = 1'b0;
        sample_chan.valid     = 1'b0;
        sample_chan.sample_in = '0;
        cfg_chan.valid        = 1'b0;
        cfg_chan.index        = CFG_B0;
        cfg_chan.data         = '0;
        probe = '{16'sd0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 16'sd1, -16'sd1,
                  16'sd0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int pass = 0; pass < 3; pass++)
        begin
            if (pass == 1)
                load_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
            else if (pass == 2)
                load_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
            foreach (probe[k])
                send_sample(probe[k]);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick_filter(filt_kind_t'($urandom_range(FILT_LOWPASS, FILT_RESET_FB)));
            send_idle  = ($urandom_range(0, 3) != 0);
            recv_stall = ($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_PHASE) send_sample(draw_sample());
        end

        sample_chan.valid <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("biquad_iir_filter_unit: match");
        else
            $display("biquad_iir_filter_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/biq_pkg.sv
rtl/core/biq_if.sv
rtl/core/biq_serial_mult.sv
rtl/core/biquad_iir_filter_unit.sv
verif/biq_response_checker.sv
verif/tb_biquad_iir_filter_unit.sv
